@@ src/sssd_pkg.sv @@
package sssd_pkg;

  localparam int unsigned MaxSpheresDef = 16;
  localparam int unsigned GridDimDef    = 1024;
  localparam int unsigned FracBitsDef   = 16;

  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    CFG_SPHERE_COUNT = 3'd0,
    CFG_ORIGIN_X     = 3'd1,
    CFG_ORIGIN_Y     = 3'd2,
    CFG_ORIGIN_Z     = 3'd3,
    CFG_STEP_X       = 3'd4,
    CFG_STEP_Y       = 3'd5,
    CFG_STEP_Z       = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_EVAL = 1'b1
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PADD,
    ST_READ,
    ST_DIFF,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_ACC,
    ST_FINISH
  } state_e;

  // one table entry, as held in the sphere memory
  typedef struct packed {
    logic        neg;
    logic [31:0] radius;
    logic [31:0] ctr_z;
    logic [31:0] ctr_y;
    logic [31:0] ctr_x;
  } sphere_t;

endpackage

@@ src/sssd_ram.sv @@
module sssd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sphere_set_signed_distance.sv @@
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser req_type, tdata load or grid fields
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata level_value
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// sequence: a load beat writes one table entry; an evaluate beat runs PMUL, PADD, then per active
//   sphere READ, DIFF, SQUARE, SUM, a 32-step iterative square root and ACC, then FINISH to hand over
// reset: rst_ni resets control, configuration (steps to one) and output valid; table contents stay undefined
// stalls: a new beat is taken while a finished result still waits on m_axis; a finished value
//   waits in the sequencer only while the output register is still full
module sphere_set_signed_distance #(
  parameter int unsigned MAX_SPHERES = sssd_pkg::MaxSpheresDef,
  parameter int unsigned GRID_DIM    = sssd_pkg::GridDimDef,
  parameter int unsigned FRAC_BITS   = sssd_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: entry_index, centre x, centre y, centre z, sphere_radius, inside_req,
  //        grid_i, grid_j, grid_k (lowest bit up), zero filled
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sssd_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: req_type
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: level_value
  output logic [sssd_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sssd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sssd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import sssd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned AddrW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned SphW = $bits(sphere_t);
  localparam logic [16:0] GridMax = 17'(GRID_DIM - 1);
  localparam logic [30:0] StepOne = 31'(64'd1 << FRAC_BITS);

  // configuration registers
  logic [4:0]  count_q;
  logic [31:0] org_x_q, org_y_q, org_z_q;
  logic [30:0] stp_x_q, stp_y_q, stp_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      stp_x_q <= StepOne;
      stp_y_q <= StepOne;
      stp_z_q <= StepOne;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SPHERE_COUNT: count_q <= cfg_data_i[4:0];
        CFG_ORIGIN_X:     org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:     org_y_q <= cfg_data_i;
        CFG_ORIGIN_Z:     org_z_q <= cfg_data_i;
        CFG_STEP_X:       stp_x_q <= cfg_data_i[30:0];
        CFG_STEP_Y:       stp_y_q <= cfg_data_i[30:0];
        CFG_STEP_Z:       stp_z_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [3:0]  in_entry;
  logic [9:0]  in_gi, in_gj, in_gk;
  sphere_t     in_sph;
  assign in_entry        = s_axis_tdata[3:0];
  assign in_sph.ctr_x    = s_axis_tdata[35:4];
  assign in_sph.ctr_y    = s_axis_tdata[67:36];
  assign in_sph.ctr_z    = s_axis_tdata[99:68];
  assign in_sph.radius   = s_axis_tdata[131:100];
  assign in_sph.neg      = s_axis_tdata[132];
  assign in_gi           = s_axis_tdata[142:133];
  assign in_gj           = s_axis_tdata[152:143];
  assign in_gk           = s_axis_tdata[162:153];

  function automatic logic [9:0] clamp_idx(input logic [9:0] idx);
    logic [16:0] w;
    w = {7'd0, idx};
    if (w > GridMax) w = GridMax;
    return w[9:0];
  endfunction

  state_e state_q, state_d;
  logic   in_acc, is_load, is_eval;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign is_load = in_acc && (req_type_e'(s_axis_tuser) == REQ_LOAD);
  assign is_eval = in_acc && (req_type_e'(s_axis_tuser) == REQ_EVAL);

  // sphere table
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [SphW-1:0]  ram_rdata;
  sphere_t          rd_sph;
  logic [CntW-1:0]  sph_q;

  assign ram_we    = is_load && ({5'd0, in_entry} < 9'(MAX_SPHERES));
  assign ram_waddr = AddrW'(in_entry);
  assign ram_re    = (state_q == ST_READ);
  assign rd_sph    = sphere_t'(ram_rdata);

  sssd_ram #(.Width(SphW), .Depth(MAX_SPHERES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (SphW'(in_sph)),
    .re_i    (ram_re),
    .raddr_i (sph_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // datapath registers
  logic [CntW-1:0] n_q;
  logic [9:0]      gi_q, gj_q, gk_q;
  logic [40:0]     prod_x_q, prod_y_q, prod_z_q;
  logic [41:0]     px_q, py_q, pz_q;
  logic [31:0]     ax_q, ay_q, az_q;
  logic            big_q;
  logic [63:0]     sx_q, sy_q, sz_q;
  logic [63:0]     rad_n_q;
  logic            ovf_q;
  logic [34:0]     rem_q;
  logic [31:0]     root_q;
  logic [4:0]      iter_q;
  logic [31:0]     best_q;
  logic            m_valid_q;
  logic [31:0]     m_data_q;

  // difference of point and centre per axis
  logic [42:0] dx, dy, dz, adx, ady, adz;
  assign dx  = {px_q[41], px_q} - 43'(signed'(rd_sph.ctr_x));
  assign dy  = {py_q[41], py_q} - 43'(signed'(rd_sph.ctr_y));
  assign dz  = {pz_q[41], pz_q} - 43'(signed'(rd_sph.ctr_z));
  assign adx = dx[42] ? -dx : dx;
  assign ady = dy[42] ? -dy : dy;
  assign adz = dz[42] ? -dz : dz;

  // square sum, with carry out to spot overflow past 64 bits
  logic [65:0] sum3;
  assign sum3 = {2'b0, sx_q} + {2'b0, sy_q} + {2'b0, sz_q};

  // one root bit per cycle
  logic [34:0] rem_sh, trial;
  logic        take;
  assign rem_sh = {rem_q[32:0], rad_n_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;

  // sphere value, saturated
  logic [32:0] span;
  logic [34:0] val, sval;
  logic [31:0] sat;
  assign span = ovf_q ? 33'h1_0000_0000 : {1'b0, root_q};
  assign val  = {2'b0, span} - 35'(signed'(rd_sph.radius));
  assign sval = rd_sph.neg ? -val : val;
  always_comb begin
    if (!sval[34] && (sval[33:31] != 3'b000)) sat = 32'h7fff_ffff;
    else if (sval[34] && (sval[33:31] != 3'b111)) sat = 32'h8000_0000;
    else sat = sval[31:0];
  end

  logic last_sph, out_free;
  assign last_sph = (sph_q + CntW'(1)) == n_q;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (is_eval) state_d = ST_PMUL;
      ST_PMUL:   state_d = ST_PADD;
      ST_PADD:   state_d = (n_q == '0) ? ST_FINISH : ST_READ;
      ST_READ:   state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_ROOT;
      ST_ROOT:   if (iter_q == 5'd31) state_d = ST_ACC;
      ST_ACC:    state_d = last_sph ? ST_FINISH : ST_READ;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      sph_q     <= '0;
      iter_q    <= '0;
      n_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (is_eval) begin
        n_q   <= (9'(count_q) > 9'(MAX_SPHERES)) ? CntW'(MAX_SPHERES) : CntW'(count_q);
        sph_q <= '0;
      end else if (state_q == ST_ACC) begin
        sph_q <= sph_q + CntW'(1);
      end
      if (state_q == ST_ROOT) iter_q <= iter_q + 5'd1;
      else iter_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_eval) begin
      gi_q <= clamp_idx(in_gi);
      gj_q <= clamp_idx(in_gj);
      gk_q <= clamp_idx(in_gk);
    end
    if (state_q == ST_PMUL) begin
      prod_x_q <= stp_x_q * gi_q;
      prod_y_q <= stp_y_q * gj_q;
      prod_z_q <= stp_z_q * gk_q;
    end
    if (state_q == ST_PADD) begin
      px_q   <= 42'(signed'(org_x_q)) + {1'b0, prod_x_q};
      py_q   <= 42'(signed'(org_y_q)) + {1'b0, prod_y_q};
      pz_q   <= 42'(signed'(org_z_q)) + {1'b0, prod_z_q};
      best_q <= 32'h8000_0000;
    end
    if (state_q == ST_DIFF) begin
      ax_q  <= adx[31:0];
      ay_q  <= ady[31:0];
      az_q  <= adz[31:0];
      big_q <= (adx[42:32] != '0) || (ady[42:32] != '0) || (adz[42:32] != '0);
    end
    if (state_q == ST_SQUARE) begin
      sx_q <= ax_q * ax_q;
      sy_q <= ay_q * ay_q;
      sz_q <= az_q * az_q;
    end
    if (state_q == ST_SUM) begin
      rad_n_q <= sum3[63:0];
      ovf_q   <= big_q || (sum3[65:64] != 2'b00);
      rem_q   <= '0;
      root_q  <= '0;
    end
    if (state_q == ST_ROOT) begin
      rad_n_q <= {rad_n_q[61:0], 2'b00};
      rem_q   <= take ? rem_sh - trial : rem_sh;
      root_q  <= {root_q[30:0], take};
    end
    if (state_q == ST_ACC && ($signed(sat) > $signed(best_q))) begin
      best_q <= sat;
    end
    if (state_q == ST_FINISH && out_free) begin
      m_data_q <= best_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`ifndef NO_ASSERTIONS
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (sph_q < n_q))
    else $error("sphere read beyond active count");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MAX_SPHERES))
    else $error("active count above table depth");
  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("finished value not handed to output");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("table written during evaluation");
`endif

endmodule
